### sv/gwm_pkg.sv
package gwm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_NAME    = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_ANY     = 2'd1,
    KIND_STAR    = 2'd2,
    KIND_CLASS   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL      = 3'd0,
    MODE_ESCAPE      = 3'd1,
    MODE_CLASS_START = 3'd2,
    MODE_CLASS_BODY  = 3'd3,
    MODE_CLASS_DASH  = 3'd4
  } mode_t;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // write command broadcast along the cell row
  typedef struct packed {
    logic       new_elem;
    logic [1:0] kind;
    logic [7:0] literal;
    logic       set_invert;
    logic       add_range;
    logic [7:0] lo;
    logic [7:0] hi;
  } wr_t;

endpackage

### sv/gwm_if.sv
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink (input valid, matched, pattern_overflow, output ready);
endinterface

### sv/gwm_cell.sv
module gwm_cell import gwm_pkg::*; #(
  parameter int MAX_RANGES = 4
) (
  input  logic       clk,
  input  logic       sel,
  input  logic       last_sel,
  input  wr_t        wr,
  input  logic [7:0] name_b,
  output logic       is_star,
  output logic       take
);
  localparam int RW = $clog2(MAX_RANGES + 1);

  logic [1:0] kind;
  logic       invert;
  logic [7:0] literal;
  logic [RW-1:0] rcount;
  logic [MAX_RANGES-1:0][7:0] rlo;
  logic [MAX_RANGES-1:0][7:0] rhi;
  logic hit;

  always_ff @(posedge clk) begin
    if (sel && wr.new_elem) begin
      kind    <= wr.kind;
      literal <= wr.literal;
      invert  <= 1'b0;
      rcount  <= '0;
    end
    if (last_sel && wr.set_invert) invert <= 1'b1;
    if (last_sel && wr.add_range && rcount < RW'(MAX_RANGES)) begin
      rlo[rcount[$clog2(MAX_RANGES > 1 ? MAX_RANGES : 2)-1:0]] <= wr.lo;
      rhi[rcount[$clog2(MAX_RANGES > 1 ? MAX_RANGES : 2)-1:0]] <= wr.hi;
      rcount <= rcount + RW'(1);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int r = 0; r < MAX_RANGES; r++)
      if (RW'(r) < rcount && name_b >= rlo[r] && name_b <= rhi[r]) hit = 1'b1;
    is_star = kind == KIND_STAR;
    case (kind)
      KIND_LITERAL: take = literal == name_b;
      KIND_ANY:     take = 1'b1;
      KIND_STAR:    take = 1'b0;
      default:      take = hit ^ invert;
    endcase
  end
endmodule

### sv/glob_wildcard_matcher_top.sv
// Shell glob matcher. Pattern bytes (command 1) build a row of element cells;
// name bytes (command 2) move a row of active bits one step through the cells;
// command 3 gives one result item (matched, pattern_overflow). Every command
// is accepted at one item a cycle, with ready held low only while a result
// waits in the output register and the sink stalls. A pattern holds at most
// MAX_ELEMENTS elements of MAX_RANGES class entries each; beyond that the
// overflow flag is set and matching fails until the next clear.
module glob_wildcard_matcher_top import gwm_pkg::*; #(
  parameter int MAX_ELEMENTS = 32,
  parameter int MAX_RANGES   = 4
) (
  input logic clk,
  input logic rst,
  gwm_in_if.sink    in_ch,
  gwm_out_if.source out_ch
);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int N  = MAX_ELEMENTS;
  localparam int RW = $clog2(MAX_RANGES + 1);

  logic [CW-1:0] count;
  mode_t         mode;
  logic [8:0]    prev;
  logic [N:0]    act;
  logic          ovf;
  logic          stored;
  logic          acc;
  wr_t           wr;
  logic [N-1:0]  star, take, sel, lsel;
  logic [N:0]    closed, stepped, after;
  logic [7:0]    c;
  logic          add_ok;

  // range fill tracking mirrored per element to spot range overflow
  logic [N-1:0][RW-1:0] rc;

  function automatic logic g_rc_ok(input int i);
    return rc[i] < RW'(MAX_RANGES);
  endfunction

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign c = in_ch.data_byte;
  assign add_ok = count < CW'(N);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign sel[g]  = count == CW'(g);
      assign lsel[g] = stored && (count == CW'(g + 1));
      gwm_cell #(.MAX_RANGES(MAX_RANGES)) u_cell (
        .clk(clk), .sel(sel[g] && acc), .last_sel(lsel[g] && acc), .wr(wr),
        .name_b(c), .is_star(star[g]), .take(take[g])
      );
    end
  endgenerate

  always_comb begin
    closed = act;
    for (int i = 0; i < N; i++)
      if (closed[i] && star[i] && CW'(i) < count) closed[i+1] = 1'b1;
    stepped = '0;
    for (int i = 0; i < N; i++)
      if (closed[i] && CW'(i) < count) begin
        if (star[i]) stepped[i] = 1'b1;
        else if (take[i]) stepped[i+1] = 1'b1;
      end
    after = stepped;
    for (int i = 0; i < N; i++)
      if (after[i] && star[i] && CW'(i) < count) after[i+1] = 1'b1;
  end

  always_comb begin
    wr = '0;
    wr.lo = prev[7:0];
    wr.hi = c;
    wr.literal = c;
    wr.kind = KIND_LITERAL;
    if (in_ch.command == CMD_PATTERN) begin
      unique case (mode)
        MODE_ESCAPE: wr.new_elem = 1'b1;
        MODE_CLASS_START, MODE_CLASS_BODY: begin
          if (mode == MODE_CLASS_START && c == CH_BANG) wr.set_invert = 1'b1;
          else if (c != CH_RBRK && c != CH_DASH) begin
            wr.add_range = 1'b1;
            wr.lo = c;
          end
        end
        MODE_CLASS_DASH: wr.add_range = !prev[8];
        default: begin
          if (c == CH_QUERY) begin
            wr.new_elem = 1'b1; wr.kind = KIND_ANY;
          end else if (c == CH_STAR) begin
            wr.new_elem = 1'b1; wr.kind = KIND_STAR;
          end else if (c == CH_LBRK) begin
            wr.new_elem = 1'b1; wr.kind = KIND_CLASS;
          end else if (c != CH_BSL) wr.new_elem = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; mode <= MODE_NORMAL; prev <= 9'h100; ovf <= 1'b0;
      stored <= 1'b0; act <= (N+1)'(1); out_ch.valid <= 1'b0;
    end else begin
      if (acc && in_ch.command == CMD_END) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (acc) begin
        case (in_ch.command)
          CMD_CLEAR: begin
            count <= '0; mode <= MODE_NORMAL; prev <= 9'h100; ovf <= 1'b0;
            stored <= 1'b0; act <= (N+1)'(1);
          end
          CMD_PATTERN: begin
            act <= (N+1)'(1);
            if (wr.new_elem) begin
              if (add_ok) count <= count + CW'(1);
              else ovf <= 1'b1;
            end
            if (wr.add_range && stored && count != '0) begin
              for (int i = 0; i < N; i++)
                if (lsel[i] && !(g_rc_ok(i))) ovf <= 1'b1;
            end
            unique case (mode)
              MODE_ESCAPE: mode <= MODE_NORMAL;
              MODE_CLASS_START, MODE_CLASS_BODY: begin
                if (mode == MODE_CLASS_START && c == CH_BANG) mode <= MODE_CLASS_BODY;
                else if (c == CH_RBRK) mode <= MODE_NORMAL;
                else if (c == CH_DASH) mode <= MODE_CLASS_DASH;
                else begin
                  prev <= {1'b0, c}; mode <= MODE_CLASS_BODY;
                end
              end
              MODE_CLASS_DASH: begin
                prev <= {1'b0, c}; mode <= MODE_CLASS_BODY;
              end
              default: begin
                if (c == CH_BSL) mode <= MODE_ESCAPE;
                else if (c == CH_LBRK) begin
                  stored <= add_ok; prev <= 9'h100; mode <= MODE_CLASS_START;
                end
              end
            endcase
          end
          CMD_NAME: act <= after;
          default: begin
            out_ch.matched <= closed[count] && mode != MODE_ESCAPE && !ovf;
            out_ch.pattern_overflow <= ovf;
            act <= (N+1)'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (acc && sel[i] && wr.new_elem) rc[i] <= '0;
      else if (acc && lsel[i] && wr.add_range && rc[i] < RW'(MAX_RANGES))
        rc[i] <= rc[i] + RW'(1);
    end
  end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import gwm_pkg::*;

  localparam int MAX_E      = 32;
  localparam int MAX_R      = 4;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    bit matched;
    bit overflow;
  } verdict_t;

  logic clk;
  logic rst;

  gwm_in_if  in_ch ();
  gwm_out_if out_ch ();

  glob_wildcard_matcher_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // pattern store and matcher state
  kind_t    el_kind [MAX_E];
  bit       el_inv  [MAX_E];
  bit [7:0] el_lit  [MAX_E];
  bit [7:0] cls_lo  [MAX_E*MAX_R];
  bit [7:0] cls_hi  [MAX_E*MAX_R];
  int       cls_cnt [MAX_E];
  int       el_count;
  mode_t    parse_mode;
  int       prev_byte;
  bit [MAX_E:0] live;
  bit       ovf;
  bit       cls_kept;

  verdict_t verdicts [$];
  int       errors;
  int       items_sent;
  int       tx_gap_pct;
  int       rx_stall_pct;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void restart_name();
    live    = '0;
    live[0] = 1'b1;
  endfunction

  function automatic void close_stars();
    for (int i = 0; i < el_count; i++)
      if (live[i] && el_kind[i] == KIND_STAR) live[i+1] = 1'b1;
  endfunction

  function automatic bit add_elem(kind_t k, bit [7:0] l);
    if (el_count >= MAX_E) begin
      ovf = 1'b1;
      return 1'b0;
    end
    el_kind[el_count] = k;
    el_inv[el_count]  = 1'b0;
    el_lit[el_count]  = l;
    cls_cnt[el_count] = 0;
    el_count++;
    return 1'b1;
  endfunction

  function automatic void add_entry(bit [7:0] lo, bit [7:0] hi);
    int e;
    if (!cls_kept || el_count == 0) return;
    e = el_count - 1;
    if (cls_cnt[e] >= MAX_R) begin
      ovf = 1'b1;
      return;
    end
    cls_lo[e*MAX_R + cls_cnt[e]] = lo;
    cls_hi[e*MAX_R + cls_cnt[e]] = hi;
    cls_cnt[e]++;
  endfunction

  function automatic void class_byte(bit [7:0] c);
    if (c == CH_RBRK) parse_mode = MODE_NORMAL;
    else if (c == CH_DASH) parse_mode = MODE_CLASS_DASH;
    else begin
      add_entry(c, c);
      prev_byte  = c;
      parse_mode = MODE_CLASS_BODY;
    end
  endfunction

  function automatic void decode_pattern_byte(bit [7:0] c);
    case (parse_mode)
      MODE_ESCAPE: begin
        void'(add_elem(KIND_LITERAL, c));
        parse_mode = MODE_NORMAL;
      end
      MODE_CLASS_START: begin
        if (c == CH_BANG) begin
          if (cls_kept && el_count > 0) el_inv[el_count-1] = 1'b1;
          parse_mode = MODE_CLASS_BODY;
        end else class_byte(c);
      end
      MODE_CLASS_BODY: class_byte(c);
      MODE_CLASS_DASH: begin
        if (prev_byte != 256) add_entry(prev_byte[7:0], c);
        prev_byte  = c;
        parse_mode = MODE_CLASS_BODY;
      end
      default: begin
        if (c == CH_BSL) parse_mode = MODE_ESCAPE;
        else if (c == CH_QUERY) void'(add_elem(KIND_ANY, 8'd0));
        else if (c == CH_STAR) void'(add_elem(KIND_STAR, 8'd0));
        else if (c == CH_LBRK) begin
          cls_kept   = add_elem(KIND_CLASS, 8'd0);
          prev_byte  = 256;
          parse_mode = MODE_CLASS_START;
        end else void'(add_elem(KIND_LITERAL, c));
      end
    endcase
  endfunction

  function automatic bit class_hit(int e, bit [7:0] b);
    bit hit = 1'b0;
    for (int r = 0; r < cls_cnt[e]; r++)
      if (b >= cls_lo[e*MAX_R + r] && b <= cls_hi[e*MAX_R + r]) hit = 1'b1;
    return hit ^ el_inv[e];
  endfunction

  function automatic void advance_name(bit [7:0] b);
    bit [MAX_E:0] nxt = '0;
    bit take;
    close_stars();
    for (int i = 0; i < el_count; i++) begin
      if (live[i]) begin
        case (el_kind[i])
          KIND_LITERAL: take = (el_lit[i] == b);
          KIND_ANY:     take = 1'b1;
          KIND_STAR: begin
            take   = 1'b0;
            nxt[i] = 1'b1;
          end
          default:      take = class_hit(i, b);
        endcase
        if (take) nxt[i+1] = 1'b1;
      end
    end
    live = nxt;
    close_stars();
  endfunction

  function automatic void predict_item(cmd_t cmd, bit [7:0] b);
    verdict_t v;
    case (cmd)
      CMD_CLEAR: begin
        el_count   = 0;
        parse_mode = MODE_NORMAL;
        prev_byte  = 256;
        ovf        = 1'b0;
        cls_kept   = 1'b0;
        restart_name();
      end
      CMD_PATTERN: begin
        decode_pattern_byte(b);
        restart_name();
      end
      CMD_NAME: advance_name(b);
      default: begin
        close_stars();
        v.matched  = live[el_count] && parse_mode != MODE_ESCAPE && !ovf;
        v.overflow = ovf;
        verdicts.push_back(v);
        restart_name();
      end
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, bit [7:0] b);
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(cmd, b);
    items_sent++;
  endtask

  task automatic load_pattern(string p);
    send_item(CMD_CLEAR, 8'($urandom));
    for (int i = 0; i < p.len(); i++) send_item(CMD_PATTERN, p[i]);
  endtask

  task automatic try_name(string n);
    for (int i = 0; i < n.len(); i++) send_item(CMD_NAME, n[i]);
    send_item(CMD_END, 8'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (verdicts.size() == 0) report("result item with none expected");
      else begin
        v = verdicts.pop_front();
        if (out_ch.matched !== v.matched)
          report($sformatf("matched %b, expected %b", out_ch.matched, v.matched));
        if (out_ch.pattern_overflow !== v.overflow)
          report($sformatf("pattern_overflow %b, expected %b",
                           out_ch.pattern_overflow, v.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic test_literals_and_wildcards();
    load_pattern("");
    try_name("");
    try_name("a");
    load_pattern("a*b?c");
    try_name("abxc");
    try_name("axxxbyc");
    try_name("abc");
    load_pattern("\\*\\");
    try_name("*");
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_PATTERN, 8'hFF);
    send_item(CMD_PATTERN, 8'h00);
    send_item(CMD_NAME, 8'hFF);
    send_item(CMD_NAME, 8'h00);
    send_item(CMD_END, 8'hFF);
  endtask

  task automatic test_classes();
    load_pattern("[!a-c]x[]-]");
    try_name("dx]");
    try_name("bx-");
    load_pattern("[-z][z-a][a-");
    try_name("aaa");
    try_name("-zaa");
    load_pattern("[ab");
    try_name("b");
  endtask

  task automatic test_overflow();
    load_pattern("[abcde]");
    try_name("a");
    send_item(CMD_CLEAR, 8'h00);
    for (int i = 0; i < MAX_E + 1; i++) send_item(CMD_PATTERN, CH_QUERY);
    send_item(CMD_PATTERN, CH_LBRK);
    send_item(CMD_PATTERN, "a");
    try_name("");
    load_pattern("a");
    try_name("a");
  endtask

  function automatic bit [7:0] random_pattern_byte();
    case ($urandom_range(15))
      0, 1, 2: return CH_STAR;
      3, 4:    return CH_QUERY;
      5, 6:    return CH_LBRK;
      7:       return CH_RBRK;
      8:       return CH_DASH;
      9:       return CH_BANG;
      10:      return ($urandom_range(7) == 0) ? CH_BSL : "b";
      11:      return 8'($urandom);
      default: return 8'("a" + $urandom_range(3));
    endcase
  endfunction

  task automatic test_random(int target);
    string pat;
    bit [7:0] c;
    int plen;
    while (items_sent < target) begin
      plen = ($urandom_range(19) == 0) ? $urandom_range(MAX_E + 6) : $urandom_range(8);
      pat = "";
      for (int i = 0; i < plen; i++) pat = {pat, string'(random_pattern_byte())};
      load_pattern(pat);
      repeat ($urandom_range(1, 4)) begin
        for (int i = 0; i < pat.len(); i++) begin
          c = pat[i];
          if ($urandom_range(9) == 0) send_item(CMD_NAME, 8'($urandom));
          else if (c == CH_STAR)
            repeat ($urandom_range(2)) send_item(CMD_NAME, 8'("a" + $urandom_range(3)));
          else if (c == CH_QUERY || c == CH_LBRK || c == CH_RBRK || c == CH_DASH)
            send_item(CMD_NAME, 8'("a" + $urandom_range(3)));
          else if (c != CH_BSL && $urandom_range(7) != 0) send_item(CMD_NAME, c);
        end
        case ($urandom_range(19))
          0: send_item(CMD_CLEAR, 8'($urandom));
          1: send_item(CMD_PATTERN, random_pattern_byte());
          default: ;
        endcase
        send_item(CMD_END, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_CLEAR;
    in_ch.data_byte = 8'h00;
    out_ch.ready    = 1'b0;
    errors          = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    el_count        = 0;
    parse_mode      = MODE_NORMAL;
    prev_byte       = 256;
    ovf             = 1'b0;
    cls_kept        = 1'b0;
    restart_name();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_literals_and_wildcards();
    test_classes();
    test_overflow();
    test_random(items_sent + 300);
    drain();
    tx_gap_pct = 85;
    test_random(items_sent + 300);
    tx_gap_pct   = 0;
    rx_stall_pct = 85;
    test_random(items_sent + 300);
    tx_gap_pct   = 7;
    rx_stall_pct = 7;
    test_random(items_sent + 300);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
